/* rtl/frt_pkg.sv */
// ----------------------------------------------------------------------------
// frt_pkg
// shared types, codes and constants of the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned SLOTS_DEF         = 16;
  localparam int unsigned MAX_FRAGMENTS_DEF = 64;

  localparam logic [31:0] BEST_START = 32'h7FFF_FFFE;
  localparam logic [31:0] NO_FRAME   = 32'hFFFF_FFFF;

  // request codes
  localparam logic [2:0] REQ_FRAGMENT = 3'd0;
  localparam logic [2:0] REQ_RETRIEVE = 3'd1;
  localparam logic [2:0] REQ_RELEASE  = 3'd2;
  localparam logic [2:0] REQ_NEXT     = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_STALE      = 3'd1;
  localparam logic [2:0] ST_TOO_LONG   = 3'd2;
  localparam logic [2:0] ST_FRAG_RANGE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;
  localparam logic [2:0] ST_NONE_AVAIL = 3'd6;

  // register indexes
  localparam logic [1:0] REG_FRAGS   = 2'd0;
  localparam logic [1:0] REG_PAYLOAD = 2'd1;
  localparam logic [1:0] REG_HEADER  = 2'd2;
  localparam logic [1:0] REG_PACKET  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] frame_count;
    logic [15:0] frag_idx;
    logic [15:0] received_length;
    logic [31:0] arrival_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [19:0] write_offset;
    logic [15:0] write_length;
    logic        frame_complete;
    logic        evicted;
    logic [31:0] frame_count_out;
    logic [31:0] arrival_time_out;
  } rsp_t;

  typedef struct packed {
    logic [6:0]  frags;
    logic [15:0] payload;
    logic [7:0]  header;
    logic [19:0] packet;
  } cfg_t;

endpackage

/* rtl/frt_if.sv */
// ----------------------------------------------------------------------------
// frt_req_if / frt_rsp_if
// valid/ready channels carrying requests and results
// ----------------------------------------------------------------------------
interface frt_req_if;
  import frt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frt_rsp_if;
  import frt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/frt_front.sv */
// ----------------------------------------------------------------------------
// frt_front
// accepts requests and queues them for the table engine
// ----------------------------------------------------------------------------
module frt_front
  import frt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  frt_req_if.sink in_ch,
  output logic q_valid,
  output req_t q_data,
  input  logic q_pop
);

  // two-entry queue
  req_t       buf_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = buf_r[rd_ptr_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop && q_valid) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(in_ch.valid && in_ch.ready) - 2'(q_pop && q_valid);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) buf_r[wr_ptr_r] <= in_ch.data;
  end

endmodule

/* rtl/frt_engine.sv */
// ----------------------------------------------------------------------------
// frt_engine
// slot table and request sequencer: match, search, update, answer
// ----------------------------------------------------------------------------
module frt_engine
  import frt_pkg::*;
#(
  parameter int unsigned SLOTS         = SLOTS_DEF,
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  req_t q_data,
  output logic q_pop,
  frt_rsp_if.source out_ch,
  output logic busy
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = MAX_FRAGMENTS;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t       state_r;
  req_t         req_r;
  rsp_t         rsp_r;
  rsp_t         rsp_nxt;
  logic         out_valid_r;

  logic [SLOTS-1:0] valid_r;
  logic [31:0]      frame_r [SLOTS];
  logic [FW-1:0]    bits_r  [SLOTS];
  logic [31:0]      arr_r   [SLOTS];
  logic [31:0]      lr_frame_r;
  logic             lr_valid_r;

  // scan results
  logic [CW-1:0] idx_r;
  logic          match_r, free_r, found_r, stop_r;
  logic [SW-1:0] match_s_r, free_s_r, old_s_r, best_s_r;
  logic [31:0]   old_f_r, best_d_r;

  // fragment count clamp and completion mask
  logic [6:0]    nfr;
  logic [FW-1:0] cmask;
  always_comb begin
    nfr = cfg.frags;
    if (nfr == 7'd0) nfr = 7'd1;
    if (nfr > 7'(FW)) nfr = 7'(FW);
    for (int k = 0; k < FW; k++) cmask[k] = (7'(k) < nfr);
  end

  // scan element
  logic [SW-1:0] si;
  logic          s_valid, s_cmp;
  logic [31:0]   s_frame, s_d;
  assign si      = idx_r[SW-1:0];
  assign s_valid = valid_r[si];
  assign s_frame = frame_r[si];
  assign s_cmp   = ((bits_r[si] & cmask) == cmask);
  assign s_d     = s_frame - req_r.frame_count;

  // fragment arithmetic on the chosen slot
  logic [SW-1:0] tgt;
  logic          evict;
  logic [FW-1:0] tbits, nbits;
  logic [35:0]   off_w;
  logic [36:0]   end_w;
  logic [15:0]   plen;
  logic          too_long, fset;
  logic [2:0]    fst;
  always_comb begin
    evict = 1'b0;
    if (match_r) tgt = match_s_r;
    else if (free_r) tgt = free_s_r;
    else begin
      tgt   = old_s_r;
      evict = 1'b1;
    end
    tbits = match_r ? bits_r[tgt] : '0;
    off_w = 36'(cfg.header) + 36'(req_r.frag_idx) * 36'(cfg.payload);
    plen  = req_r.received_length - 16'(cfg.header);
    end_w = 37'(off_w) + 37'(plen);
    fset  = 1'b0;
    fst   = ST_OK;
    nbits = tbits;
    if (req_r.frag_idx == 16'd0) begin
      too_long = (20'(req_r.received_length) > cfg.packet);
      if (too_long) fst = ST_TOO_LONG;
      else fset = 1'b1;
    end else if (req_r.frag_idx < 16'(nfr)) begin
      too_long = (req_r.received_length < 16'(cfg.header)) ||
                 (end_w > 37'(cfg.packet));
      if (too_long) fst = ST_TOO_LONG;
      else fset = 1'b1;
    end else begin
      too_long = 1'b0;
      fst      = ST_FRAG_RANGE;
    end
    for (int k = 0; k < FW; k++)
      if (fset && (32'(k) == 32'(req_r.frag_idx))) nbits[k] = 1'b1;
  end

  // stale fragment, matched slot completion and release set
  logic             stale, m_cmp;
  logic [SLOTS-1:0] rel_mask;
  assign stale = lr_valid_r && (req_r.frame_count <= lr_frame_r);
  assign m_cmp = ((bits_r[match_s_r] & cmask) == cmask);
  always_comb begin
    for (int k = 0; k < SLOTS; k++)
      rel_mask[k] = (SW'(k) == match_s_r) ||
                    (valid_r[k] && frame_r[k] < req_r.frame_count);
  end

  // result of the current request
  always_comb begin
    rsp_nxt = '0;
    case (req_r.req_type) inside
      REQ_FRAGMENT: begin
        if (stale) rsp_nxt.status = ST_STALE;
        else begin
          rsp_nxt.status         = fst;
          rsp_nxt.slot_index     = 4'(tgt);
          rsp_nxt.evicted        = evict && !match_r;
          rsp_nxt.frame_complete = ((nbits & cmask) == cmask);
          if (fset) begin
            rsp_nxt.write_length = (req_r.frag_idx == 16'd0) ?
                                   req_r.received_length : plen;
            rsp_nxt.write_offset = (req_r.frag_idx == 16'd0) ?
                                   20'd0 : off_w[19:0];
          end
        end
      end
      REQ_RETRIEVE, REQ_RELEASE: begin
        if (!match_r) rsp_nxt.status = ST_NOT_FOUND;
        else begin
          rsp_nxt.slot_index = 4'(match_s_r);
          if (!m_cmp) rsp_nxt.status = ST_INCOMPLETE;
          else if (req_r.req_type == REQ_RETRIEVE) begin
            rsp_nxt.frame_complete   = 1'b1;
            rsp_nxt.arrival_time_out = arr_r[match_s_r];
          end
        end
      end
      REQ_NEXT: begin
        if (!found_r) rsp_nxt.status = ST_NONE_AVAIL;
        else begin
          rsp_nxt.slot_index      = 4'(best_s_r);
          rsp_nxt.frame_count_out = req_r.frame_count + best_d_r;
        end
      end
      default: ;
    endcase
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;
  assign busy       = (state_r != S_IDLE) || out_valid_r;

  // sequencer: one slot per cycle in the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      lr_valid_r  <= 1'b0;
      lr_frame_r  <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        frame_r[k] <= '0;
        bits_r[k]  <= '0;
      end
    end else begin
      // the update only runs once the previous result is gone or is being taken
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r     <= q_data;
            idx_r     <= '0;
            match_r   <= 1'b0;
            free_r    <= 1'b0;
            found_r   <= 1'b0;
            stop_r    <= 1'b0;
            old_f_r   <= NO_FRAME;
            old_s_r   <= '0;
            best_d_r  <= BEST_START;
            match_s_r <= '0;
            free_s_r  <= '0;
            best_s_r  <= '0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (s_valid && s_frame == req_r.frame_count && !match_r) begin
            match_r   <= 1'b1;
            match_s_r <= si;
          end
          if (!s_valid && !free_r) begin
            free_r   <= 1'b1;
            free_s_r <= si;
          end
          if (s_valid && s_frame < old_f_r) begin
            old_f_r <= s_frame;
            old_s_r <= si;
          end
          if (s_valid && s_cmp && !stop_r && s_d <= best_d_r) begin
            best_d_r <= s_d;
            best_s_r <= si;
            found_r  <= 1'b1;
            if (s_d == 32'd0) stop_r <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
          if (idx_r == CW'(SLOTS - 1)) state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!out_valid_r || out_ch.ready) begin
            rsp_r <= rsp_nxt;
            case (req_r.req_type)
              REQ_FRAGMENT: begin
                if (!stale) begin
                  valid_r[tgt] <= 1'b1;
                  frame_r[tgt] <= req_r.frame_count;
                  bits_r[tgt]  <= nbits;
                  arr_r[tgt]   <= req_r.arrival_time;
                end
              end
              REQ_RETRIEVE: begin
                if (match_r && m_cmp) begin
                  lr_valid_r <= 1'b1;
                  lr_frame_r <= req_r.frame_count;
                end
              end
              REQ_RELEASE: begin
                if (match_r && m_cmp) begin
                  valid_r <= valid_r & ~rel_mask;
                  for (int k = 0; k < SLOTS; k++)
                    if (rel_mask[k]) bits_r[k] <= '0;
                end
              end
              REQ_CLEAR: begin
                lr_valid_r <= 1'b0;
                lr_frame_r <= '0;
              end
              default: ;
            endcase
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/frt_regs.sv */
// ----------------------------------------------------------------------------
// frt_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module frt_regs
  import frt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [1:0] ridx;
  assign ridx       = cfg_paddr[3:2];
  assign cfg        = cfg_r;
  assign cfg_pready = 1'b1;

  // register write on access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frags   <= 7'd1;
      cfg_r.payload <= 16'd1436;
      cfg_r.header  <= 8'd64;
      cfg_r.packet  <= 20'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_FRAGS:   cfg_r.frags   <= cfg_pwdata[6:0];
        REG_PAYLOAD: cfg_r.payload <= cfg_pwdata[15:0];
        REG_HEADER:  cfg_r.header  <= cfg_pwdata[7:0];
        REG_PACKET:  cfg_r.packet  <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (ridx)
      REG_FRAGS:   cfg_prdata = 32'(cfg_r.frags);
      REG_PAYLOAD: cfg_prdata = 32'(cfg_r.payload);
      REG_HEADER:  cfg_prdata = 32'(cfg_r.header);
      REG_PACKET:  cfg_prdata = 32'(cfg_r.packet);
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

/* rtl/fragment_reassembly_tracker_core.sv */
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_core
// slot table tracking fragments of numbered frames
// ----------------------------------------------------------------------------
// For each request the table engine walks one slot per cycle to find the
// match, the lowest free slot, the oldest frame and the nearest complete
// frame, then updates the table and registers the result. The update waits
// while the previous result has not been taken, so a stalled receiver adds
// its stall cycles. A two-entry request queue in front keeps taking
// transfers, until it is full, while the engine works or the result waits.
module fragment_reassembly_tracker_core
  import frt_pkg::*;
#(
  parameter int unsigned SLOTS         = SLOTS_DEF,
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  frt_req_if.sink     in_ch,
  frt_rsp_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  logic q_valid, q_pop, busy;
  req_t q_data;

  frt_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  frt_front u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_data, .q_pop
  );

  frt_engine #(.SLOTS(SLOTS), .MAX_FRAGMENTS(MAX_FRAGMENTS)) u_engine (
    .clk, .rst_n, .cfg, .q_valid, .q_data, .q_pop, .out_ch, .busy
  );

  // checks
  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
    else $error("result changed while stalled");
  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> busy) else $error("result without busy");

endmodule
